// ===== sv/kmp_pkg.sv =====
// Shared types and constants for the KMP substring search unit.
package kmp_pkg;

  // Width of the match start field and of the packed result word
  localparam int MATCH_W    = 32;
  localparam int OUT_DATA_W = 40;

  // Sequencer states of the search engine
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BEGIN,
    ST_WALK_RD,
    ST_WALK_CMP,
    ST_TAIL_RD,
    ST_TAIL_WB,
    ST_FINISH
  } kmp_state_t;

  // Request start and its kind, from the stream side to the engine
  typedef struct packed {
    logic start;
    logic is_text;
    logic first;
  } kmp_cmd_t;

  // Engine status back to the stream side
  typedef struct packed {
    logic busy;
    logic done;
  } kmp_status_t;

  // Result of one request
  typedef struct packed {
    logic               found;
    logic [MATCH_W-1:0] match_start;
    logic               overflow;
  } kmp_result_t;

endpackage

// ===== sv/kmp_substring_search_unit.sv =====
// Top level: stream ports, request handoff and registered result for KMP search.
// Sequence: a request passes the BEGIN and FINISH states; when a compare is needed
//   (not for an empty pattern, a held match, or a first or dropped pattern symbol)
//   it also passes WALK_RD and WALK_CMP, again for each step back along a failure link,
//   and TAIL_RD and TAIL_WB when a text symbol completes the first match.
// Handoff: one request at a time; the next is accepted the cycle after the result
//   is taken.
// Reset: rst clears the sequencer, lengths, counters and flags; the pattern and
//   failure memories are not cleared and need no clearing pass.
module kmp_substring_search_unit #(
  parameter int MAX_PATTERN = 256,
  parameter int SYMBOL_BITS = 16,
  parameter int INDEX_BITS  = 32
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    s_tvalid,
  output logic                                    s_tready,
  input  logic [((SYMBOL_BITS+7)/8)*8-1:0]        s_tdata,  // symbol
  input  logic [1:0]                              s_tuser,  // operation, first
  output logic                                    m_tvalid,
  input  logic                                    m_tready,
  output logic [kmp_pkg::OUT_DATA_W-1:0]          m_tdata   // found, match_start, pattern_overflow
);
  import kmp_pkg::*;

  kmp_cmd_t    cmd;
  kmp_status_t status;
  kmp_result_t result;

  // Take a request only when the engine and the result register are free
  assign s_tready    = !status.busy && !m_tvalid;
  assign cmd.start   = s_tvalid && s_tready;
  assign cmd.is_text = s_tuser[0];
  assign cmd.first   = s_tuser[1];

  kmp_engine #(
    .MAX_PATTERN(MAX_PATTERN),
    .SYMBOL_BITS(SYMBOL_BITS),
    .INDEX_BITS (INDEX_BITS)
  ) u_engine (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd),
    .symbol(s_tdata[SYMBOL_BITS-1:0]),
    .status(status),
    .result(result)
  );

  // Hold the result until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (status.done) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (status.done) begin
      m_tdata <= {{(OUT_DATA_W-MATCH_W-2){1'b0}}, result.overflow, result.match_start,
                  result.found};
    end
  end

endmodule

// ===== sv/kmp_engine.sv =====
// Search engine: pattern and failure memories, border walk sequencer and search state.
module kmp_engine #(
  parameter int MAX_PATTERN = 256,
  parameter int SYMBOL_BITS = 16,
  parameter int INDEX_BITS  = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  kmp_pkg::kmp_cmd_t      cmd,
  input  logic [SYMBOL_BITS-1:0] symbol,
  output kmp_pkg::kmp_status_t   status,
  output kmp_pkg::kmp_result_t   result
);
  import kmp_pkg::*;

  localparam int ADDR_W = $clog2(MAX_PATTERN);
  localparam int LEN_W  = $clog2(MAX_PATTERN + 1);
  localparam int SUM_W  = (INDEX_BITS > LEN_W) ? INDEX_BITS : LEN_W;

  kmp_state_t state, state_next;

  // Latched request
  logic [SYMBOL_BITS-1:0] sym_q;
  logic                   is_text_q;
  logic                   first_q;

  // Search state
  logic [LEN_W-1:0]      len;
  logic [ADDR_W-1:0]     cand;
  logic [ADDR_W-1:0]     matched;
  logic [INDEX_BITS-1:0] tidx;
  logic                  found_flag;
  logic [INDEX_BITS-1:0] found_pos;
  logic                  ovf;
  logic [LEN_W-1:0]      k;

  // Memories
  logic [SYMBOL_BITS-1:0] pat_mem [MAX_PATTERN];
  logic [ADDR_W-1:0]      fail_mem [MAX_PATTERN];
  logic [SYMBOL_BITS-1:0] p_rd;
  logic [ADDR_W-1:0]      f_rd;
  logic                   p_we, f_we;
  logic [ADDR_W-1:0]      p_waddr, p_raddr, f_waddr, f_raddr, f_wdata;

  // Datapath terms
  logic [LEN_W-1:0] len_eff, k_new, len_m1, k_m1;
  logic             pat_full, found_eff, hit, step_back, at_end;
  logic [SUM_W-1:0] pos_full;
  logic [MATCH_W-1:0] pos32;

  assign len_eff   = (first_q && !is_text_q) ? '0 : len;
  assign pat_full  = len_eff >= LEN_W'(MAX_PATTERN);
  assign found_eff = first_q ? 1'b0 : found_flag;
  assign hit       = (p_rd == sym_q);
  assign step_back = (k != '0) && !hit;
  assign k_new     = k + LEN_W'(hit);
  assign at_end    = k_new >= len;
  assign len_m1    = len - LEN_W'(1);
  assign k_m1      = k - LEN_W'(1);
  assign pos_full  = SUM_W'(tidx) + SUM_W'(1) - SUM_W'(len);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd.start) state_next = ST_BEGIN;
      end
      ST_BEGIN: begin
        if (is_text_q) begin
          state_next = (found_eff || len == '0) ? ST_FINISH : ST_WALK_RD;
        end else begin
          state_next = (pat_full || len_eff == '0) ? ST_FINISH : ST_WALK_RD;
        end
      end
      ST_WALK_RD:  state_next = ST_WALK_CMP;
      ST_WALK_CMP: begin
        if (step_back) state_next = ST_WALK_RD;
        else if (is_text_q && at_end) state_next = ST_TAIL_RD;
        else state_next = ST_FINISH;
      end
      ST_TAIL_RD: state_next = ST_TAIL_WB;
      ST_TAIL_WB: state_next = ST_FINISH;
      ST_FINISH:  state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // Memory control and status
  always_comb begin
    status.busy = (state != ST_IDLE);
    status.done = (state == ST_FINISH);
    p_we    = (state == ST_BEGIN) && !is_text_q && !pat_full;
    p_waddr = len_eff[ADDR_W-1:0];
    p_raddr = k[ADDR_W-1:0];
    f_we    = ((state == ST_BEGIN) && !is_text_q && !pat_full && len_eff == '0) ||
              ((state == ST_WALK_CMP) && !is_text_q && !step_back);
    f_waddr = (state == ST_BEGIN) ? '0 : len[ADDR_W-1:0];
    f_wdata = (state == ST_BEGIN) ? '0 : k_new[ADDR_W-1:0];
    f_raddr = (state == ST_TAIL_RD) ? len_m1[ADDR_W-1:0] : k_m1[ADDR_W-1:0];
  end

  // Pattern memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (p_we) pat_mem[p_waddr] <= sym_q;
    p_rd <= pat_mem[p_raddr];
  end

  // Failure link memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (f_we) fail_mem[f_waddr] <= f_wdata;
    f_rd <= fail_mem[f_raddr];
  end

  // Latch the request
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && cmd.start) begin
      sym_q     <= symbol;
      is_text_q <= cmd.is_text;
      first_q   <= cmd.first;
    end
  end

  // Walk register
  always_ff @(posedge clk) begin
    if (state == ST_BEGIN) begin
      k <= is_text_q ? (first_q ? '0 : LEN_W'(matched)) : LEN_W'(cand);
    end else if (state == ST_WALK_CMP && step_back) begin
      k <= LEN_W'(f_rd);
    end
  end

  // Search state updates
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      len        <= '0;
      cand       <= '0;
      matched    <= '0;
      tidx       <= '0;
      found_flag <= 1'b0;
      found_pos  <= '0;
      ovf        <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        ST_BEGIN: begin
          if (!is_text_q) begin
            // every pattern symbol drops the current scan
            matched    <= '0;
            tidx       <= '0;
            found_flag <= 1'b0;
            found_pos  <= '0;
            if (first_q) begin
              ovf <= 1'b0;
            end
            // a restart always lands in the empty-pattern arm below
            if (pat_full) begin
              ovf <= 1'b1;
            end else if (len_eff == '0) begin
              cand <= '0;
              len  <= LEN_W'(1);
            end
          end else begin
            // empty pattern matches at the start
            if (!found_eff && len == '0) begin
              found_flag <= 1'b1;
              found_pos  <= '0;
              tidx       <= first_q ? INDEX_BITS'(1) : tidx + INDEX_BITS'(1);
            end else if (first_q) begin
              // restart the scan
              matched    <= '0;
              tidx       <= '0;
              found_flag <= 1'b0;
              found_pos  <= '0;
            end
          end
        end
        ST_WALK_CMP: begin
          if (!step_back) begin
            if (!is_text_q) begin
              cand <= k_new[ADDR_W-1:0];
              len  <= len + LEN_W'(1);
            end else begin
              tidx <= tidx + INDEX_BITS'(1);
              if (at_end) begin
                found_flag <= 1'b1;
                found_pos  <= pos_full[INDEX_BITS-1:0];
              end else begin
                matched <= k_new[ADDR_W-1:0];
              end
            end
          end
        end
        ST_TAIL_WB: begin
          matched <= f_rd;
        end
        default: begin
        end
      endcase
    end
  end

  // Fit the start index to the result field
  generate
    if (INDEX_BITS >= MATCH_W) begin : g_pos_cut
      assign pos32 = found_pos[MATCH_W-1:0];
    end else begin : g_pos_ext
      assign pos32 = {{(MATCH_W-INDEX_BITS){1'b0}}, found_pos};
    end
  endgenerate

  assign result.found       = found_flag;
  assign result.match_start = found_flag ? pos32 : '0;
  assign result.overflow    = ovf;

  // The walk never reaches past the stored pattern
  a_walk_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK_CMP) |-> (k < len))
    else $error("border walk index beyond pattern length");

  // The partial match stays a proper prefix
  a_matched_proper: assert property (@(posedge clk) disable iff (rst)
    (len != '0) |-> (LEN_W'(matched) < len))
    else $error("matched count not below pattern length");

  // Overflow only with a full pattern store
  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
    ovf |-> (len == LEN_W'(MAX_PATTERN)))
    else $error("overflow flagged with room left");

  // Completion lasts one cycle and leaves the engine idle
  a_done_once: assert property (@(posedge clk) disable iff (rst)
    status.done |=> (!status.done && state == ST_IDLE))
    else $error("completion not followed by idle");

endmodule

// ===== tb/sv/kmp_substring_search_unit_tb.sv =====
// Testbench for the KMP substring search unit: directed table, random rounds, self-checking.
`timescale 1ns / 100ps

module kmp_substring_search_unit_tb;
  import kmp_pkg::*;

  localparam int CLK_PERIOD     = 4;
  localparam int RESET_CYCLES   = 9;
  localparam int MAX_PAT        = 256;
  localparam int ITEM_TARGET    = 1400;
  localparam int MAX_GAP        = 13;
  localparam int HOLD_AT        = 300;
  localparam int HOLD_CYCLES    = 250;
  localparam int DRAIN_CYCLES   = 16;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int REPORT_LIMIT   = 10;

  typedef enum logic {
    OP_PATTERN = 1'b0,
    OP_TEXT    = 1'b1
  } sym_op_t;

  // One row of the directed table; want is used only where typed is set
  typedef struct packed {
    sym_op_t     op;
    logic [15:0] sym;
    logic        first;
    logic        typed;
    kmp_result_t want;
  } stim_row_t;

  localparam kmp_result_t UNTYPED   = '0;
  localparam kmp_result_t HIT_AT_0  = '{1'b1, 32'd0, 1'b0};
  localparam kmp_result_t NO_HIT    = '{1'b0, 32'd0, 1'b0};

  localparam stim_row_t DIRECTED [22] = '{
    // empty pattern matches at once, then holds
    '{OP_TEXT,    16'h0000, 1'b1, 1'b1, HIT_AT_0},
    '{OP_TEXT,    16'hFFFF, 1'b0, 1'b1, HIT_AT_0},
    // pattern load clears the search
    '{OP_PATTERN, 16'h0000, 1'b1, 1'b1, NO_HIT},
    '{OP_PATTERN, 16'hFFFF, 1'b0, 1'b1, NO_HIT},
    '{OP_PATTERN, 16'h0000, 1'b0, 1'b1, NO_HIT},
    // match at index 1, hold, then restart the scan
    '{OP_TEXT,    16'hFFFF, 1'b1, 1'b0, UNTYPED},
    '{OP_TEXT,    16'h0000, 1'b0, 1'b0, UNTYPED},
    '{OP_TEXT,    16'hFFFF, 1'b0, 1'b0, UNTYPED},
    '{OP_TEXT,    16'h0000, 1'b0, 1'b0, UNTYPED},
    '{OP_TEXT,    16'h1234, 1'b0, 1'b0, UNTYPED},
    '{OP_TEXT,    16'h0000, 1'b1, 1'b0, UNTYPED},
    // repeated prefix forces a failure-link walk
    '{OP_PATTERN, 16'h5555, 1'b1, 1'b1, NO_HIT},
    '{OP_PATTERN, 16'h5555, 1'b0, 1'b1, NO_HIT},
    '{OP_PATTERN, 16'hAAAA, 1'b0, 1'b1, NO_HIT},
    '{OP_TEXT,    16'h5555, 1'b1, 1'b0, UNTYPED},
    '{OP_TEXT,    16'h5555, 1'b0, 1'b0, UNTYPED},
    '{OP_TEXT,    16'h5555, 1'b0, 1'b0, UNTYPED},
    '{OP_TEXT,    16'hAAAA, 1'b0, 1'b0, UNTYPED},
    // single-symbol pattern
    '{OP_PATTERN, 16'h00FF, 1'b1, 1'b1, NO_HIT},
    '{OP_TEXT,    16'h1111, 1'b1, 1'b0, UNTYPED},
    '{OP_TEXT,    16'h00FF, 1'b0, 1'b0, UNTYPED},
    '{OP_TEXT,    16'h00FF, 1'b1, 1'b0, UNTYPED}
  };

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata  = '0;   // symbol
  logic [1:0]  s_tuser  = '0;   // operation, first
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;  // found, match_start, pattern_overflow

  // Search state mirrored from the block
  bit [15:0]   pat_mem    [MAX_PAT];
  bit [8:0]    border_tab [MAX_PAT];
  int unsigned pat_len;
  int unsigned cand_len;
  int unsigned matched_len;
  bit [31:0]   txt_idx;
  bit [31:0]   hit_pos;
  bit          hit;
  bit          pat_ovf;

  kmp_result_t expected_results [$];
  logic [15:0] cur_pattern [$];

  int  items_sent;
  int  pattern_reqs;
  int  text_reqs;
  int  results_seen;
  int  hits_seen;
  int  ovf_seen;
  int  mismatches;
  int  stall_cycles;
  bit  sender_fast;
  bit  sink_fast;
  bit  hold_done;
  bit  overflow_done;

  kmp_substring_search_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Extend a border of length k by symbol c, falling back along the links
  function automatic int unsigned extend_border(int unsigned k, logic [15:0] c);
    while (k > 0 && k < MAX_PAT && pat_mem[k] != c)
      k = 32'(border_tab[k - 1]);
    if (k < MAX_PAT && pat_mem[k] == c)
      k++;
    return k;
  endfunction

  function automatic void clear_scan();
    matched_len = 0;
    txt_idx     = '0;
    hit         = 1'b0;
    hit_pos     = '0;
  endfunction

  // Advance the mirrored search by one request and return its result
  function automatic kmp_result_t search_step(sym_op_t op, logic [15:0] c, logic first);
    kmp_result_t res;
    int unsigned k;
    if (op == OP_TEXT) begin
      if (first)
        clear_scan();
      if (!hit) begin
        if (pat_len == 0) begin
          hit     = 1'b1;
          hit_pos = '0;
        end else begin
          k = extend_border(matched_len, c);
          if (k >= pat_len) begin
            hit     = 1'b1;
            hit_pos = txt_idx + 32'd1 - 32'(pat_len);
            k       = 32'(border_tab[pat_len - 1]);
          end
          matched_len = k;
        end
        txt_idx = txt_idx + 32'd1;
      end
    end else begin
      if (first) begin
        pat_len  = 0;
        cand_len = 0;
        pat_ovf  = 1'b0;
      end
      clear_scan();
      if (pat_len >= MAX_PAT) begin
        pat_ovf = 1'b1;
      end else begin
        pat_mem[pat_len] = c;
        if (pat_len == 0) begin
          border_tab[0] = '0;
          cand_len      = 0;
        end else begin
          k                   = extend_border(cand_len, c);
          border_tab[pat_len] = 9'(k);
          cand_len            = k;
        end
        pat_len++;
      end
    end
    res.found       = hit;
    res.match_start = hit ? hit_pos : '0;
    res.overflow    = pat_ovf;
    return res;
  endfunction

  // Offer one request, wait for the handshake, queue its expected result
  task automatic push_request(sym_op_t op, logic [15:0] sym, logic first,
                              bit typed = 1'b0, kmp_result_t want = '0);
    int gap;
    kmp_result_t predicted;
    gap = sender_fast ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= sym;
    s_tuser  <= {first, op};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predicted = search_step(op, sym, first);
    expected_results.push_back(typed ? want : predicted);
    items_sent++;
    if (op == OP_TEXT)
      text_reqs++;
    else
      pattern_reqs++;
  endtask

  // Hold the input until every queued result has come back
  task automatic wait_for_drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  // One random round: noise, or an optional new pattern followed by a text scan
  task automatic run_round();
    int pick;
    int nsym;
    int plen;
    int tlen;
    logic [15:0] alpha [4];
    logic [15:0] txt [$];
    pick        = $urandom_range(0, 9);
    sender_fast = ($urandom_range(0, 3) == 0);
    nsym        = $urandom_range(1, 4);
    foreach (alpha[i]) alpha[i] = 16'($urandom);
    if (pick == 0) begin
      repeat ($urandom_range(4, 12))
        push_request(sym_op_t'($urandom_range(0, 1)), 16'($urandom),
                     1'($urandom_range(0, 1)));
      return;
    end
    if (pick >= 3 || cur_pattern.size() == 0) begin
      plen = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
      cur_pattern.delete();
      for (int i = 0; i < plen; i++)
        cur_pattern.push_back(alpha[$urandom_range(0, nsym - 1)]);
      foreach (cur_pattern[i])
        push_request(OP_PATTERN, cur_pattern[i], (i == 0) && ($urandom_range(0, 9) != 0));
    end
    // build text from pattern copies and symbols close to the pattern's alphabet
    tlen = $urandom_range(1, 32);
    while (txt.size() < tlen) begin
      if ($urandom_range(0, 4) == 0)
        foreach (cur_pattern[i]) txt.push_back(cur_pattern[i]);
      else if ($urandom_range(0, 1) == 0)
        txt.push_back(cur_pattern[$urandom_range(0, cur_pattern.size() - 1)]);
      else
        txt.push_back(alpha[$urandom_range(0, nsym - 1)]);
    end
    foreach (txt[i])
      push_request(OP_TEXT, txt[i],
                   (i == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 24) == 0));
    if ($urandom_range(0, 7) == 0)
      wait_for_drain();
  endtask

  // Fill the pattern past capacity, then scan through a deep link walk to a match
  task automatic run_overflow_round();
    logic [15:0] fill;
    int n;
    fill        = 16'($urandom);
    sender_fast = 1'b1;
    n           = MAX_PAT + 2 + $urandom_range(0, 2);
    for (int i = 0; i < n; i++)
      push_request(OP_PATTERN, fill, i == 0);
    for (int i = 0; i < 100; i++)
      push_request(OP_TEXT, fill, i == 0);
    push_request(OP_TEXT, ~fill, 1'b0);
    repeat (MAX_PAT) push_request(OP_TEXT, fill, 1'b0);
    push_request(OP_TEXT, ~fill, 1'b0);
    cur_pattern.delete();
    cur_pattern.push_back(fill);
    wait_for_drain();
  endtask

  // Compare one result word with the oldest expectation
  task automatic check_result(logic [OUT_DATA_W-1:0] word);
    kmp_result_t got;
    kmp_result_t want;
    got.found       = word[0];
    got.match_start = word[MATCH_W:1];
    got.overflow    = word[MATCH_W+1];
    if (got.found)
      hits_seen++;
    if (got.overflow)
      ovf_seen++;
    if (expected_results.size() == 0) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("[%0t] unexpected result: found=%0b start=%0d overflow=%0b",
                 $realtime, got.found, got.match_start, got.overflow);
    end else begin
      want = expected_results.pop_front();
      if (got.found !== want.found || got.match_start !== want.match_start ||
          got.overflow !== want.overflow) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("[%0t] result %0d: expected found=%0b start=%0d overflow=%0b,",
                   $realtime, results_seen, want.found, want.match_start, want.overflow,
                   " got found=%0b start=%0d overflow=%0b",
                   got.found, got.match_start, got.overflow);
      end
    end
  endtask

  // Result side: random back-pressure, one long hold-off, fast stretches
  initial begin
    int gap;
    while (rst) @(posedge clk);
    forever begin
      if (results_seen == HOLD_AT && !hold_done) begin
        hold_done = 1'b1;
        gap       = HOLD_CYCLES;
      end else begin
        gap = sink_fast ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      check_result(m_tdata);
      results_seen++;
      if ($urandom_range(0, 39) == 0)
        sink_fast = ~sink_fast;
    end
  end

  // Abort when no request moves on either side for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Request side: reset, directed table, random rounds with one overflow round, final drain
  initial begin
    pat_len  = 0;
    cand_len = 0;
    pat_ovf  = 1'b0;
    clear_scan();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    foreach (DIRECTED[i])
      push_request(DIRECTED[i].op, DIRECTED[i].sym, DIRECTED[i].first,
                   DIRECTED[i].typed, DIRECTED[i].want);
    wait_for_drain();
    while (items_sent < ITEM_TARGET) begin
      if (!overflow_done && items_sent >= 500) begin
        run_overflow_round();
        overflow_done = 1'b1;
      end else begin
        run_round();
      end
    end
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Ran %0d requests (%0d pattern, %0d text) and checked %0d results,",
             items_sent, pattern_reqs, text_reqs, results_seen);
    $display("%0d of them with a match and %0d with the pattern overflow flag; %0d mismatches.",
             hits_seen, ovf_seen, mismatches);
    if (mismatches == 0 && expected_results.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
